[rtl/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg - shared types and constants for the HSV/HSL to RGB unit
// Widths, chroma-part codes, per-channel term bundle and the sector lookup.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HUE_W               = 11;
  localparam int LEVEL_W             = 8;
  localparam int CHAN_W              = 8;
  localparam int HUE_SECTOR_BITS_DEF = 8;

  // P, Q and the secondary term all stay below 2^17 (max 510*255)
  localparam int TERM_W = 17;

  // floor(z/255) = (z * 32897) >> 23, exact for any 16-bit z
  localparam int          DIV_IN_W  = 16;
  localparam int          DIV_PRD_W = 32;
  localparam int          DIV_SHIFT = 23;
  localparam logic [15:0] DIV_RECIP = 16'd32897;

  // which part of the chroma a channel receives
  typedef enum logic [1:0] {
    PART_ZERO,
    PART_CHROMA,
    PART_SECOND
  } part_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_idx_t;

  // terms shared by all three channels
  typedef struct packed {
    logic [TERM_W-1:0] p;   // full chroma term
    logic [TERM_W-1:0] q;   // offset term
    logic [TERM_W-1:0] px;  // secondary chroma term
  } chan_terms_t;

  // sector code 6 and 7 both mean full circle: no chroma
  function automatic part_t part_sel(input logic [2:0] sec, input chan_idx_t ch);
    part_t r;
    part_t g;
    part_t b;
    part_t res;
    r = PART_ZERO;
    g = PART_ZERO;
    b = PART_ZERO;
    unique case (sec)
      3'd0: begin r = PART_CHROMA; g = PART_SECOND; b = PART_ZERO;   end
      3'd1: begin r = PART_SECOND; g = PART_CHROMA; b = PART_ZERO;   end
      3'd2: begin r = PART_ZERO;   g = PART_CHROMA; b = PART_SECOND; end
      3'd3: begin r = PART_ZERO;   g = PART_SECOND; b = PART_CHROMA; end
      3'd4: begin r = PART_SECOND; g = PART_ZERO;   b = PART_CHROMA; end
      3'd5: begin r = PART_CHROMA; g = PART_ZERO;   b = PART_SECOND; end
      default: begin r = PART_ZERO; g = PART_ZERO; b = PART_ZERO; end
    endcase
    unique case (ch)
      CH_RED:   res = r;
      CH_GREEN: res = g;
      CH_BLUE:  res = b;
      default:  res = PART_ZERO;
    endcase
    return res;
  endfunction

endpackage

[rtl/hsvrgb_chan.sv]
// ----------------------------------------------------------------------------
// hsvrgb_chan - one output channel: term select, add, divide by 510
// Two register stages: reciprocal product, then the byte result.
// ----------------------------------------------------------------------------
module hsvrgb_chan (
  input  logic                      clk,
  input  logic                      en,
  input  hsvrgb_pkg::part_t         sel,
  input  hsvrgb_pkg::chan_terms_t   terms,
  output logic [hsvrgb_pkg::CHAN_W-1:0] chan
);

  logic [hsvrgb_pkg::TERM_W-1:0]    addend;
  logic [hsvrgb_pkg::TERM_W:0]      sum;
  logic [hsvrgb_pkg::DIV_IN_W-1:0]  half;
  logic [hsvrgb_pkg::DIV_PRD_W-1:0] prod;

  always_comb begin
    case (sel)
      hsvrgb_pkg::PART_CHROMA: addend = terms.p;
      hsvrgb_pkg::PART_SECOND: addend = terms.px;
      default:                 addend = '0;
    endcase
  end

  // sum < 510*256, so sum/2 fits 16 bits; floor(sum/510) = floor((sum>>1)/255)
  assign sum  = {1'b0, terms.q} + {1'b0, addend};
  assign half = sum[hsvrgb_pkg::DIV_IN_W:1];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= hsvrgb_pkg::DIV_PRD_W'(half) *
              hsvrgb_pkg::DIV_PRD_W'(hsvrgb_pkg::DIV_RECIP);
      chan <= prod[hsvrgb_pkg::DIV_SHIFT +: hsvrgb_pkg::CHAN_W];
    end
  end

endmodule

[rtl/hsv_hsl_to_rgb_unit.sv]
// ----------------------------------------------------------------------------
// hsv_hsl_to_rgb_unit - HSV / HSL to 8-bit RGB color converter
// Four-stage pipeline, one color per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries hue, saturation, level.
//   Output channel (out_valid / out_stall) carries red, green, blue.
//   A transaction completes on a clock edge with valid high and stall low.
//   cfg_wen / cfg_wdata write color_model (0 = HSV, 1 = HSL); write it only
//   while no transaction is in flight.
// Stages: four registers (operand product, chroma terms, reciprocal product,
//   result byte); one transaction per cycle while the output is not stalled.
// Reset (rst, synchronous): clears all stage valids and color_model to HSV.
// Stall: out_stall with a valid result freezes every stage; in_stall then
//   rises in the same cycle, so nothing is dropped or repeated. Bubbles
//   in the pipe do not hold up the input.
// Hue: 1/2^HUE_SECTOR_BITS of a 60-degree sector; sector 6 and above
//   (360 degrees on) give no chroma, all channels equal the offset.
// ----------------------------------------------------------------------------
module hsv_hsl_to_rgb_unit #(
  parameter int HUE_SECTOR_BITS = hsvrgb_pkg::HUE_SECTOR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hsvrgb_pkg::HUE_W-1:0]    hue,
  input  logic [hsvrgb_pkg::LEVEL_W-1:0]  saturation,
  input  logic [hsvrgb_pkg::LEVEL_W-1:0]  level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsvrgb_pkg::CHAN_W-1:0]   red,
  output logic [hsvrgb_pkg::CHAN_W-1:0]   green,
  output logic [hsvrgb_pkg::CHAN_W-1:0]   blue
);

  localparam int B      = HUE_SECTOR_BITS;
  localparam int SEC_W  = (hsvrgb_pkg::HUE_W > B) ? hsvrgb_pkg::HUE_W - B : 1;
  localparam int TW     = hsvrgb_pkg::TERM_W;
  localparam int LW     = hsvrgb_pkg::LEVEL_W;

  logic color_model;

  // stage valids
  logic v1, v2, v3, v4;
  logic en;

  // stage 1 registers
  logic [2*LW-1:0] m1;       // (HSV: level, HSL: a) * saturation
  logic [LW-1:0]   lvl1;
  logic            mode1;
  logic [2:0]      sec1;     // 0..5, or 7 for full circle
  logic [B:0]      t1;       // weight of the secondary term

  // stage 2 registers
  hsvrgb_pkg::chan_terms_t terms2;
  hsvrgb_pkg::part_t       sel_r2, sel_g2, sel_b2;

  // stage 1 combinational
  logic [SEC_W-1:0] sector;
  logic [B-1:0]     frac;
  logic [LW:0]      twice;
  logic [LW:0]      mid_dev;
  logic [LW-1:0]    a_hsl;
  logic [LW-1:0]    mult_op;
  logic [2:0]       sec_code;
  logic [B:0]       t_next;

  // stage 2 combinational
  logic [TW-1:0]    p_next;
  logic [TW-1:0]    q_next;
  logic [TW+B:0]    px_full;

  // whole pipe advances unless a finished result is held
  assign en       = !(v4 && out_stall);
  assign in_stall = !en;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_model <= 1'b0;
    end else if (cfg_wen) begin
      color_model <= cfg_wdata;
    end
  end

  // ---- stage 1: split hue, HSL distance, single 8x8 product ----
  generate
    if (hsvrgb_pkg::HUE_W > B) begin : g_sector
      assign sector = hue[hsvrgb_pkg::HUE_W-1:B];
    end else begin : g_no_sector
      assign sector = 1'b0;
    end
  endgenerate

  assign frac = B'(hue);

  always_comb begin
    twice = {level, 1'b0};
    mid_dev = (twice >= (LW+1)'(255)) ? twice - (LW+1)'(255) : (LW+1)'(255) - twice;
    a_hsl = LW'(255) - mid_dev[LW-1:0];
    mult_op = color_model ? a_hsl : level;
    sec_code = (32'(sector) >= 32'd6) ? 3'd7 : 3'(sector);
    // odd sectors fall, even sectors rise
    if (sector[0]) begin
      t_next = (B+1)'(1) << B;
      t_next = t_next - {1'b0, frac};
    end else begin
      t_next = {1'b0, frac};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= mult_op * saturation;
      lvl1  <= level;
      mode1 <= color_model;
      sec1  <= sec_code;
      t1    <= t_next;
    end
  end

  // ---- stage 2: chroma P, offset Q, secondary P*t/2^B ----
  always_comb begin
    p_next = {m1, 1'b0};
    // HSV: Q = 510*l - 2*l*s ; HSL: Q = 510*l - a*s
    q_next = TW'(lvl1) * TW'(510);
    q_next = q_next - (mode1 ? TW'(m1) : p_next);
    px_full = p_next * t1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms2.p  <= p_next;
      terms2.q  <= q_next;
      terms2.px <= px_full[B +: TW];
      sel_r2    <= hsvrgb_pkg::part_sel(sec1, hsvrgb_pkg::CH_RED);
      sel_g2    <= hsvrgb_pkg::part_sel(sec1, hsvrgb_pkg::CH_GREEN);
      sel_b2    <= hsvrgb_pkg::part_sel(sec1, hsvrgb_pkg::CH_BLUE);
    end
  end

  // ---- stages 3 and 4: per-channel divide by 510 ----
  hsvrgb_chan u_red (
    .clk   (clk),
    .en    (en),
    .sel   (sel_r2),
    .terms (terms2),
    .chan  (red)
  );

  hsvrgb_chan u_green (
    .clk   (clk),
    .en    (en),
    .sel   (sel_g2),
    .terms (terms2),
    .chan  (green)
  );

  hsvrgb_chan u_blue (
    .clk   (clk),
    .en    (en),
    .sel   (sel_b2),
    .terms (terms2),
    .chan  (blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

endmodule

[rtl/hsvrgb_chk.sv]
// ----------------------------------------------------------------------------
// hsvrgb_chk - port-level checks for hsv_hsl_to_rgb_unit
// Stall behavior, reset and pipeline latency seen at the ports.
// ----------------------------------------------------------------------------
module hsvrgb_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hsvrgb_pkg::CHAN_W-1:0] red,
  input logic [hsvrgb_pkg::CHAN_W-1:0] green,
  input logic [hsvrgb_pkg::CHAN_W-1:0] blue
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("output transaction changed while stalled");

  // held result backs up into the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled while output held");

  // nothing pending after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // result reaches the output when out_stall stays low behind the input
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind hsv_hsl_to_rgb_unit hsvrgb_chk u_hsvrgb_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red       (red),
  .green     (green),
  .blue      (blue)
);
